FILE: src/pwm_rpm_calibration_sweep_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the calibration sweep block
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef PWM_RPM_CALIBRATION_SWEEP_TOP_DEFINES_SVH
`define PWM_RPM_CALIBRATION_SWEEP_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/prcs_pkg.sv
// ----------------------------------------------------------------------------
// prcs_pkg
// Types and constants of the PWM to RPM calibration sweep block.
// ----------------------------------------------------------------------------
`default_nettype none

package prcs_pkg;

  // Sweep phase as reported in each result beat.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_SAMPLE = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // Action codes of an input beat; the fourth code is unused.
  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_ABORT  = 2'd2;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_PWM_START = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PWM_END   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PWM_STEP  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_MS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_MS = 3'd4;

  // Register values after reset.
  localparam logic [7:0]  RST_PWM_START = 8'd30;
  localparam logic [7:0]  RST_PWM_END   = 8'd255;
  localparam logic [7:0]  RST_PWM_STEP  = 8'd5;
  localparam logic [15:0] RST_SETTLE_MS = 16'd1500;
  localparam logic [15:0] RST_SAMPLE_MS = 16'd500;

  // Progress is given in percent.
  localparam logic [12:0] PctScale = 13'd100;

  // Shared restoring divider: operand width and steps per use.
  localparam int unsigned DivW    = 16;
  localparam int unsigned DivCntW = 5;
  localparam logic [DivCntW-1:0] AvgSteps  = 5'd16;
  localparam logic [DivCntW-1:0] TotSteps  = 5'd8;
  localparam logic [DivCntW-1:0] ProgSteps = 5'd13;

  // Sequencer states.
  typedef enum logic [2:0] {
    SEQ_IDLE = 3'd0,
    SEQ_EVAL = 3'd1,
    SEQ_AVG  = 3'd2,
    SEQ_SPAN = 3'd3,
    SEQ_TOT  = 3'd4,
    SEQ_PROG = 3'd5,
    SEQ_OUT  = 3'd6
  } seq_e;

  // Input beat.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] time_ms;
    logic [15:0] measured_rpm;
  } cal_in_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]  cal_phase;
    logic        running;
    logic        drive_valid;
    logic [7:0]  drive_pwm;
    logic        stop_after;
    logic        point_valid;
    logic [5:0]  point_index;
    logic [7:0]  point_pwm;
    logic [15:0] point_rpm;
    logic [12:0] progress_pct;
  } cal_out_t;

endpackage

`default_nettype wire

FILE: src/pwm_rpm_calibration_sweep_top.sv
// ----------------------------------------------------------------------------
// pwm_rpm_calibration_sweep_top
// Calibration sequencer that steps a PWM drive level, waits for the motor to
// settle, averages RPM samples and emits one table point per level while the table has room.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+---------------------------
//   cfg     | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//   in      | in        | in_valid_i / in_ready_o | in_data_i  (cal_in_t)
//   out     | out       | out_valid_o / out_ready_i | out_data_o (cal_out_t)
//
// From acceptance, an input beat passes through the sequencer states in order: evaluate,
// average a stored point with samples on the shared restoring divider at one quotient
// bit a cycle, check the sweep range, divide for the step count, divide for the
// percentage and load the output register; each division is skipped when not needed.
// in_ready_o is high only while the sequencer is idle; a held result stalls the
// next beat in the output state until out_ready_i frees the register. Reset is async.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_rpm_calibration_sweep_top #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [prcs_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [prcs_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  prcs_pkg::cal_in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output prcs_pkg::cal_out_t                  out_data_o
);

  localparam int unsigned PtsW = $clog2(MAX_POINTS + 1);
  localparam logic [PtsW-1:0] PtsMax = PtsW'(MAX_POINTS);

  // Configuration registers.
  logic [7:0]  pwm_start_q, pwm_end_q, pwm_step_q;
  logic [15:0] settle_ms_q, sample_ms_q;

  // Sweep state.
  prcs_pkg::phase_e phase_q, phase_d;
  logic [8:0]       level_q, level_d;
  logic [31:0]      pst_q, pst_d;
  logic [31:0]      rpm_sum_q, rpm_sum_d;
  logic [15:0]      smp_cnt_q, smp_cnt_d;
  logic [PtsW-1:0]  pts_q, pts_d;

  // Sequencer, captured input beat and result under construction.
  prcs_pkg::seq_e     seq_q, seq_d;
  prcs_pkg::cal_in_t  item_q;
  prcs_pkg::cal_out_t res_q, res_d;
  prcs_pkg::cal_out_t out_q;
  logic               out_valid_q, out_valid_d;

  // Shared divider registers.
  logic [prcs_pkg::DivW-1:0]    div_rem_q, div_rem_d;
  logic [prcs_pkg::DivW-1:0]    div_dvd_q, div_dvd_d;
  logic [prcs_pkg::DivW-1:0]    div_dvs_q, div_dvs_d;
  logic [prcs_pkg::DivCntW-1:0] div_cnt_q, div_cnt_d;

  // Evaluation results of the captured beat.
  prcs_pkg::phase_e   ev_phase;
  logic [8:0]         ev_level;
  logic [31:0]        ev_pst;
  logic [31:0]        ev_sum;
  logic [15:0]        ev_cnt;
  logic [PtsW-1:0]    ev_pts;
  prcs_pkg::cal_out_t ev_res;
  logic               ev_need_avg;

  logic [31:0] elapsed;
  logic [16:0] window;
  logic [8:0]  level_step;

  // Divider step and control.
  logic [prcs_pkg::DivW:0]   div_shift;
  logic                      div_ge;
  logic [prcs_pkg::DivW-1:0] div_rem_step, div_dvd_step;
  logic                      div_last;
  logic                      prog_ok;
  logic [7:0]                span;
  logic [12:0]               prog_num;
  logic                      out_load;

  // Configuration writes; indexes outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_start_q <= prcs_pkg::RST_PWM_START;
      pwm_end_q   <= prcs_pkg::RST_PWM_END;
      pwm_step_q  <= prcs_pkg::RST_PWM_STEP;
      settle_ms_q <= prcs_pkg::RST_SETTLE_MS;
      sample_ms_q <= prcs_pkg::RST_SAMPLE_MS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prcs_pkg::CFG_PWM_START: pwm_start_q <= cfg_wdata_i[7:0];
        prcs_pkg::CFG_PWM_END:   pwm_end_q   <= cfg_wdata_i[7:0];
        prcs_pkg::CFG_PWM_STEP:  pwm_step_q  <= cfg_wdata_i[7:0];
        prcs_pkg::CFG_SETTLE_MS: settle_ms_q <= cfg_wdata_i;
        prcs_pkg::CFG_SAMPLE_MS: sample_ms_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // State update for the captured beat.
  assign elapsed    = item_q.time_ms - pst_q;
  assign window     = {1'b0, settle_ms_q} + {1'b0, sample_ms_q};
  assign level_step = level_q + {1'b0, pwm_step_q};

  always_comb begin
    ev_phase    = phase_q;
    ev_level    = level_q;
    ev_pst      = pst_q;
    ev_sum      = rpm_sum_q;
    ev_cnt      = smp_cnt_q;
    ev_pts      = pts_q;
    ev_res      = '0;
    ev_need_avg = 1'b0;
    case (item_q.action)
      prcs_pkg::ACT_START: begin
        ev_phase = prcs_pkg::PH_SETTLE;
        ev_level = {1'b0, pwm_start_q};
        ev_pts   = '0;
        ev_pst   = item_q.time_ms;
        ev_sum   = '0;
        ev_cnt   = '0;
      end
      prcs_pkg::ACT_ABORT: begin
        ev_phase = prcs_pkg::PH_IDLE;
      end
      prcs_pkg::ACT_UPDATE: begin
        if (phase_q inside {prcs_pkg::PH_SETTLE, prcs_pkg::PH_SAMPLE}) begin
          ev_res.drive_valid = 1'b1;
          ev_res.drive_pwm   = level_q[7:0];
          if (phase_q == prcs_pkg::PH_SETTLE) begin
            if (elapsed >= 32'(settle_ms_q)) begin
              ev_phase = prcs_pkg::PH_SAMPLE;
              ev_sum   = '0;
              ev_cnt   = '0;
            end
          end else if (elapsed < 32'(window)) begin
            // Accumulate until the count saturates.
            if (smp_cnt_q != '1) begin
              ev_sum = rpm_sum_q + 32'(item_q.measured_rpm);
              ev_cnt = smp_cnt_q + 16'd1;
            end
          end else begin
            // Window closed: store the point unless the table is full, and step the level.
            if (pts_q < PtsMax) begin
              ev_res.point_valid = 1'b1;
              ev_res.point_index = 6'(pts_q);
              ev_res.point_pwm   = level_q[7:0];
              ev_pts             = pts_q + PtsW'(1);
              ev_need_avg        = (smp_cnt_q != '0);
            end
            ev_level = level_step;
            if (level_step > {1'b0, pwm_end_q}) begin
              ev_phase          = prcs_pkg::PH_DONE;
              ev_res.stop_after = 1'b1;
            end else begin
              ev_pst   = item_q.time_ms;
              ev_phase = prcs_pkg::PH_SETTLE;
            end
          end
        end
      end
      default: ;
    endcase
    ev_res.cal_phase = ev_phase;
    ev_res.running   = (ev_phase == prcs_pkg::PH_SETTLE) ||
                       (ev_phase == prcs_pkg::PH_SAMPLE);
  end

  // One restoring division step: one quotient bit per cycle.
  assign div_shift    = {div_rem_q, div_dvd_q[prcs_pkg::DivW-1]};
  assign div_ge       = (div_shift >= {1'b0, div_dvs_q});
  assign div_rem_step = div_ge ? prcs_pkg::DivW'(div_shift - {1'b0, div_dvs_q})
                               : div_shift[prcs_pkg::DivW-1:0];
  assign div_dvd_step = {div_dvd_q[prcs_pkg::DivW-2:0], div_ge};
  assign div_last     = (div_cnt_q == prcs_pkg::DivCntW'(1));

  // Progress needs a positive span and a nonzero step.
  assign prog_ok  = (pwm_step_q != '0) && (pwm_end_q > pwm_start_q);
  assign span     = pwm_end_q - pwm_start_q;
  assign prog_num = 13'(pts_q) * prcs_pkg::PctScale;

  // Sequencer next state.
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      prcs_pkg::SEQ_IDLE: if (in_valid_i) seq_d = prcs_pkg::SEQ_EVAL;
      prcs_pkg::SEQ_EVAL: seq_d = ev_need_avg ? prcs_pkg::SEQ_AVG : prcs_pkg::SEQ_SPAN;
      prcs_pkg::SEQ_AVG:  if (div_last) seq_d = prcs_pkg::SEQ_SPAN;
      prcs_pkg::SEQ_SPAN: seq_d = prog_ok ? prcs_pkg::SEQ_TOT : prcs_pkg::SEQ_OUT;
      prcs_pkg::SEQ_TOT: begin
        if (div_last) begin
          seq_d = (div_dvd_step[7:0] == '0) ? prcs_pkg::SEQ_OUT : prcs_pkg::SEQ_PROG;
        end
      end
      prcs_pkg::SEQ_PROG: if (div_last) seq_d = prcs_pkg::SEQ_OUT;
      prcs_pkg::SEQ_OUT:  if (!out_valid_q || out_ready_i) seq_d = prcs_pkg::SEQ_IDLE;
      default:            seq_d = prcs_pkg::SEQ_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and output register control.
  always_comb begin
    in_ready_o  = (seq_q == prcs_pkg::SEQ_IDLE);
    out_load    = (seq_q == prcs_pkg::SEQ_OUT) && (!out_valid_q || out_ready_i);
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Datapath: state commit, divider loads and steps, result assembly.
  always_comb begin
    phase_d   = phase_q;
    level_d   = level_q;
    pst_d     = pst_q;
    rpm_sum_d = rpm_sum_q;
    smp_cnt_d = smp_cnt_q;
    pts_d     = pts_q;
    res_d     = res_q;
    div_rem_d = div_rem_q;
    div_dvd_d = div_dvd_q;
    div_dvs_d = div_dvs_q;
    div_cnt_d = div_cnt_q;
    case (seq_q)
      prcs_pkg::SEQ_EVAL: begin
        phase_d   = ev_phase;
        level_d   = ev_level;
        pst_d     = ev_pst;
        rpm_sum_d = ev_sum;
        smp_cnt_d = ev_cnt;
        pts_d     = ev_pts;
        res_d     = ev_res;
        // The sum stays below count times 2^16, so the quotient fits 16 bits.
        div_rem_d = rpm_sum_q[31:16];
        div_dvd_d = rpm_sum_q[15:0];
        div_dvs_d = smp_cnt_q;
        div_cnt_d = prcs_pkg::AvgSteps;
      end
      prcs_pkg::SEQ_AVG: begin
        div_rem_d = div_rem_step;
        div_dvd_d = div_dvd_step;
        div_cnt_d = div_cnt_q - prcs_pkg::DivCntW'(1);
        if (div_last) begin
          res_d.point_rpm = div_dvd_step;
        end
      end
      prcs_pkg::SEQ_SPAN: begin
        // Total step count: span divided by the step.
        div_rem_d = '0;
        div_dvd_d = {span, 8'h00};
        div_dvs_d = {8'h00, pwm_step_q};
        div_cnt_d = prcs_pkg::TotSteps;
      end
      prcs_pkg::SEQ_TOT: begin
        div_rem_d = div_rem_step;
        div_dvd_d = div_dvd_step;
        div_cnt_d = div_cnt_q - prcs_pkg::DivCntW'(1);
        if (div_last) begin
          // Percent of points stored over the total step count.
          div_rem_d = '0;
          div_dvd_d = {prog_num, 3'b000};
          div_dvs_d = {8'h00, div_dvd_step[7:0]};
          div_cnt_d = prcs_pkg::ProgSteps;
        end
      end
      prcs_pkg::SEQ_PROG: begin
        div_rem_d = div_rem_step;
        div_dvd_d = div_dvd_step;
        div_cnt_d = div_cnt_q - prcs_pkg::DivCntW'(1);
        if (div_last) begin
          res_d.progress_pct = div_dvd_step[12:0];
        end
      end
      default: ;
    endcase
  end

  // Control and sweep state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= prcs_pkg::SEQ_IDLE;
      out_valid_q <= 1'b0;
      phase_q     <= prcs_pkg::PH_IDLE;
      level_q     <= '0;
      pst_q       <= '0;
      rpm_sum_q   <= '0;
      smp_cnt_q   <= '0;
      pts_q       <= '0;
      div_cnt_q   <= '0;
    end else begin
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      level_q     <= level_d;
      pst_q       <= pst_d;
      rpm_sum_q   <= rpm_sum_d;
      smp_cnt_q   <= smp_cnt_d;
      pts_q       <= pts_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= res_q;
    end
    res_q     <= res_d;
    div_rem_q <= div_rem_d;
    div_dvd_q <= div_dvd_d;
    div_dvs_q <= div_dvs_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: src/prcs_checker.sv
// ----------------------------------------------------------------------------
// prcs_checker
// Port-level checks of the calibration sweep block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pwm_rpm_calibration_sweep_top_defines.svh"

module prcs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input prcs_pkg::cal_out_t out_data_i
);

  // A stalled result beat holds its payload.
  `PRCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "result beat changed while stalled")

  // The block works on one beat at a time and is busy right after accepting.
  `PRCS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input accepted twice in a row")

  // A stored point only comes from an update that drove the motor.
  `PRCS_ASSERT_SAME(a_point_has_drive, clk_i, rst_ni, out_valid_i && out_data_i.point_valid, out_data_i.drive_valid, "point stored without a drive value")

  // The end of the sweep leaves the block in the done phase, not running.
  `PRCS_ASSERT_SAME(a_stop_is_done, clk_i, rst_ni, out_valid_i && out_data_i.stop_after, (out_data_i.cal_phase == prcs_pkg::PH_DONE) && !out_data_i.running, "stop without done phase")

endmodule

bind pwm_rpm_calibration_sweep_top prcs_checker u_prcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

FILE: sim/pwm_rpm_calibration_sweep_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calibration sweep result checker
// Watches the configuration port and both handshake channels of the sweep
// block. It keeps its own copy of the sweep state, predicts one status beat
// per accepted input beat and compares every accepted result beat field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------

module pwm_rpm_calibration_sweep_checker
  import prcs_pkg::*;
#(
  parameter int unsigned MaxPoints = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  cal_in_t             in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  cal_out_t            out_data_i,
  output int                  mismatch_cnt_o,
  output int                  pending_o
);

  // Shadow copy of the configuration registers.
  logic [7:0]  pwm_start_q;
  logic [7:0]  pwm_end_q;
  logic [7:0]  pwm_step_q;
  logic [15:0] settle_ms_q;
  logic [15:0] sample_ms_q;

  // Sweep state as the block should hold it.
  phase_e      phase_q;
  logic [8:0]  level_q;
  logic [31:0] phase_t0_q;
  logic [31:0] rpm_sum_q;
  logic [15:0] sample_cnt_q;
  logic [6:0]  points_q;

  // Status beats predicted but not yet seen on the output channel.
  cal_out_t status_due_q[$];
  int       fail_total = 0;
  int       due_total  = 0;

  assign mismatch_cnt_o = fail_total;
  assign pending_o      = due_total;

  // Stored points scaled to percent of the number of steps in the sweep.
  function automatic logic [12:0] sweep_progress();
    int span;
    int total;
    span = int'(pwm_end_q) - int'(pwm_start_q);
    if (pwm_step_q == '0 || span <= 0) return '0;
    total = span / int'(pwm_step_q);
    if (total <= 0) return '0;
    return 13'((int'(points_q) * int'(PctScale)) / total);
  endfunction

  // Applies one input beat to the shadow state and returns the status beat.
  function automatic cal_out_t advance_sweep(cal_in_t beat);
    cal_out_t    res;
    logic [31:0] elapsed;
    logic [31:0] avg_rpm;
    res     = '0;
    elapsed = beat.time_ms - phase_t0_q;
    case (beat.action)
      ACT_START: begin
        phase_q      = PH_SETTLE;
        level_q      = {1'b0, pwm_start_q};
        points_q     = '0;
        phase_t0_q   = beat.time_ms;
        rpm_sum_q    = '0;
        sample_cnt_q = '0;
      end
      ACT_ABORT: begin
        phase_q = PH_IDLE;
      end
      ACT_UPDATE: begin
        if (phase_q == PH_SETTLE || phase_q == PH_SAMPLE) begin
          res.drive_valid = 1'b1;
          res.drive_pwm   = level_q[7:0];
          if (phase_q == PH_SETTLE) begin
            // Settling ends once the settle time has passed.
            if (elapsed >= 32'(settle_ms_q)) begin
              phase_q      = PH_SAMPLE;
              rpm_sum_q    = '0;
              sample_cnt_q = '0;
            end
          end else if (elapsed < 32'(settle_ms_q) + 32'(sample_ms_q)) begin
            // Inside the window; the accumulator freezes once the count is full.
            if (sample_cnt_q != 16'hFFFF) begin
              rpm_sum_q    = rpm_sum_q + 32'(beat.measured_rpm);
              sample_cnt_q = sample_cnt_q + 16'd1;
            end
          end else begin
            // Window closed: store the point unless the table is full.
            avg_rpm = (sample_cnt_q != '0) ? rpm_sum_q / 32'(sample_cnt_q) : '0;
            if (int'(points_q) < MaxPoints) begin
              res.point_valid = 1'b1;
              res.point_index = points_q[5:0];
              res.point_pwm   = level_q[7:0];
              res.point_rpm   = avg_rpm[15:0];
              points_q        = points_q + 7'd1;
            end
            level_q = level_q + 9'(pwm_step_q);
            if (level_q > {1'b0, pwm_end_q}) begin
              phase_q        = PH_DONE;
              res.stop_after = 1'b1;
            end else begin
              phase_t0_q = beat.time_ms;
              phase_q    = PH_SETTLE;
            end
          end
        end
      end
      default: begin
        // The spare action code only reports the status.
      end
    endcase
    res.cal_phase    = phase_q;
    res.running      = (phase_q == PH_SETTLE || phase_q == PH_SAMPLE);
    res.progress_pct = sweep_progress();
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s: expected %0d, got %0d", $time, name, want, got);
      fail_total++;
    end
  endtask

  task automatic check_status(input cal_out_t want, input cal_out_t got);
    check_field("cal_phase", 32'(want.cal_phase), 32'(got.cal_phase));
    check_field("running", 32'(want.running), 32'(got.running));
    check_field("drive_valid", 32'(want.drive_valid), 32'(got.drive_valid));
    check_field("drive_pwm", 32'(want.drive_pwm), 32'(got.drive_pwm));
    check_field("stop_after", 32'(want.stop_after), 32'(got.stop_after));
    check_field("point_valid", 32'(want.point_valid), 32'(got.point_valid));
    check_field("point_index", 32'(want.point_index), 32'(got.point_index));
    check_field("point_pwm", 32'(want.point_pwm), 32'(got.point_pwm));
    check_field("point_rpm", 32'(want.point_rpm), 32'(got.point_rpm));
    check_field("progress_pct", 32'(want.progress_pct), 32'(got.progress_pct));
  endtask

  // Register writes, result checks and predictions, all on the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    cal_out_t want;
    if (!rst_ni) begin
      pwm_start_q  = RST_PWM_START;
      pwm_end_q    = RST_PWM_END;
      pwm_step_q   = RST_PWM_STEP;
      settle_ms_q  = RST_SETTLE_MS;
      sample_ms_q  = RST_SAMPLE_MS;
      phase_q      = PH_IDLE;
      level_q      = '0;
      phase_t0_q   = '0;
      rpm_sum_q    = '0;
      sample_cnt_q = '0;
      points_q     = '0;
      status_due_q.delete();
      due_total    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PWM_START: pwm_start_q = cfg_wdata_i[7:0];
          CFG_PWM_END:   pwm_end_q   = cfg_wdata_i[7:0];
          CFG_PWM_STEP:  pwm_step_q  = cfg_wdata_i[7:0];
          CFG_SETTLE_MS: settle_ms_q = cfg_wdata_i;
          CFG_SAMPLE_MS: sample_ms_q = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (status_due_q.size() == 0) begin
          $display("%0t ERROR unexpected result beat: expected none, got %p",
                   $time, out_data_i);
          fail_total++;
        end else begin
          want = status_due_q.pop_front();
          check_status(want, out_data_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        status_due_q.push_back(advance_sweep(in_data_i));
      end
      due_total = status_due_q.size();
    end
  end

endmodule

FILE: sim/tb_pwm_rpm_calibration_sweep_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calibration sweep testbench
// Drives directed and random sweeps into the block: well-formed level
// sequences with random samples and timing, broken up by aborts, restarts
// and spare codes, over many register settings. The checker beside the block
// predicts and compares; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module tb_pwm_rpm_calibration_sweep_top;
  import prcs_pkg::*;

  localparam int unsigned MaxPoints   = 64;
  localparam int          ItemGoal    = 1700;
  localparam int          DrainCycles = 48;
  localparam int          StuckLimit  = 3000;

  // The fourth action code and a register index with no register behind it.
  localparam logic [1:0]         ACT_SPARE   = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  cal_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  cal_out_t            out_data_o;

  int mismatches;
  int pending;

  // Stimulus bookkeeping and the window lengths currently loaded.
  int          beats_sent  = 0;
  int          burst_left  = 0;
  int          ready_left  = 0;
  int          stall_left  = 0;
  int          stuck_cycles = 0;
  logic [31:0] now_ms      = '0;
  logic [15:0] c_settle    = RST_SETTLE_MS;
  logic [15:0] c_sample    = RST_SAMPLE_MS;

  always #1 clk_i = ~clk_i;

  pwm_rpm_calibration_sweep_top #(
    .MAX_POINTS(MaxPoints)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  pwm_rpm_calibration_sweep_checker #(
    .MaxPoints(MaxPoints)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_i     (out_data_o),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  // Result side: ready runs of random length broken by stalls of random length.
  always @(negedge clk_i) begin
    if (ready_left > 0) begin
      out_ready_i <= 1'b1;
      ready_left--;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      ready_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 30);
      stall_left  = $urandom_range(1, 30);
      out_ready_i <= 1'b1;
    end
  end

  // Ends the run when no beat has moved on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("%0t watchdog: no beat moved for %0d cycles", $time, StuckLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Speed sample with the extremes showing up often.
  function automatic logic [15:0] pick_rpm();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly short windows so that sweeps move quickly, now and then the extremes.
  function automatic logic [15:0] pick_window();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  // Sends one input beat. Beats go out in bursts; between bursts valid drops
  // for a random gap. Entered and left at a falling edge.
  task automatic drive_cal_beat(input logic [1:0] act, input logic [31:0] ms,
                                input logic [15:0] rpm);
    int      gap;
    cal_in_t beat;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    beat.action       = act;
    beat.time_ms      = ms;
    beat.measured_rpm = rpm;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    beats_sent++;
  endtask

  // Drops valid and waits until every predicted status beat has come back.
  task automatic settle_down();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Writes all registers while the block is idle; 8-bit registers get random
  // upper data bits, and the spare index gets a write too.
  task automatic load_config(input logic [7:0] p_start, p_end, p_step,
                             input logic [15:0] p_settle, p_sample);
    logic [CfgIdxW-1:0]  idx [6];
    logic [CfgDataW-1:0] val [6];
    idx = '{CFG_PWM_START, CFG_PWM_END, CFG_PWM_STEP, CFG_SETTLE_MS,
            CFG_SAMPLE_MS, CfgIdxSpare};
    val = '{{8'($urandom()), p_start}, {8'($urandom()), p_end},
            {8'($urandom()), p_step}, p_settle, p_sample, 16'($urandom())};
    c_settle = p_settle;
    c_sample = p_sample;
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= val[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // One sweep: a start, then per level a few early updates, the update that
  // opens the window, samples inside it and the update that closes it.
  // Now and then a random beat breaks the sequence and ends the sweep.
  task automatic run_sweep(input int levels, input int beat_cap);
    logic [31:0] base;
    int          k;
    if ($urandom_range(0, 3) == 0) now_ms = $urandom();
    base = now_ms;
    drive_cal_beat(ACT_START, base, pick_rpm());
    for (int lv = 0; lv < levels && beats_sent < beat_cap; lv++) begin
      k = (c_settle == '0) ? 0 : $urandom_range(0, 2);
      repeat (k) drive_cal_beat(ACT_UPDATE, base + $urandom_range(0, c_settle - 1),
                                pick_rpm());
      drive_cal_beat(ACT_UPDATE,
                     base + c_settle + ((c_sample > 1) ? $urandom_range(0, 1) : 0),
                     pick_rpm());
      k = (c_sample == '0) ? 0 : $urandom_range(0, 6);
      repeat (k) drive_cal_beat(ACT_UPDATE,
                                base + c_settle + $urandom_range(0, c_sample - 1),
                                pick_rpm());
      base = base + c_settle + c_sample + $urandom_range(0, 2);
      drive_cal_beat(ACT_UPDATE, base, pick_rpm());
      if ($urandom_range(0, 24) == 0) begin
        drive_cal_beat(2'($urandom_range(0, 3)), $urandom(), pick_rpm());
        break;
      end
    end
    now_ms = base;
  endtask

  // Loads one setting and runs sweeps until the beat budget is spent. A sweep
  // sometimes runs one level past the end so that updates hit the done phase.
  task automatic run_phase(input logic [7:0] p_start, p_end, p_step,
                           input logic [15:0] p_settle, p_sample,
                           input int lo_levels, hi_levels, budget);
    int goal;
    int n_levels;
    int lv;
    load_config(p_start, p_end, p_step, p_settle, p_sample);
    goal = beats_sent + budget;
    if (p_step == '0) n_levels = hi_levels;
    else if (p_start > p_end) n_levels = 1;
    else n_levels = (p_end - p_start) / p_step + 1;
    while (beats_sent < goal) begin
      lv = $urandom_range(lo_levels, hi_levels);
      if (lv > n_levels) lv = n_levels;
      if ($urandom_range(0, 3) == 0) lv++;
      run_sweep(lv, goal);
    end
    settle_down();
  endtask

  initial begin
    logic [31:0] t0;
    logic [7:0]  r_start;
    logic [7:0]  r_end;
    logic [7:0]  r_step;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_PWM_START;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting: idle beats, a sweep across the timestamp wrap with the
    // window edges hit exactly, a level with no samples, abort and restarts.
    t0 = 32'hFFFF_FC00;
    drive_cal_beat(ACT_UPDATE, 32'h0, 16'hFFFF);
    drive_cal_beat(ACT_SPARE, 32'hFFFF_FFFF, 16'hFFFF);
    drive_cal_beat(ACT_ABORT, 32'h0, 16'h0);
    drive_cal_beat(ACT_START, t0, 16'h0);
    drive_cal_beat(ACT_UPDATE, t0 + 32'd1499, 16'd1);
    drive_cal_beat(ACT_SPARE, t0 + 32'd1499, 16'd7);
    drive_cal_beat(ACT_UPDATE, t0 + 32'd1500, 16'd9);
    drive_cal_beat(ACT_UPDATE, t0 + 32'd1500, 16'hFFFF);
    drive_cal_beat(ACT_UPDATE, t0 + 32'd1999, 16'h0);
    drive_cal_beat(ACT_UPDATE, t0 + 32'd1999, 16'd3);
    drive_cal_beat(ACT_UPDATE, t0 + 32'd2000, 16'd5);
    drive_cal_beat(ACT_UPDATE, t0 + 32'd3500, 16'd1);
    drive_cal_beat(ACT_UPDATE, t0 + 32'd4000, 16'd1);
    drive_cal_beat(ACT_ABORT, t0 + 32'd4001, 16'd0);
    drive_cal_beat(ACT_UPDATE, t0 + 32'd4002, 16'd2);
    drive_cal_beat(ACT_START, 32'h0, 16'd0);
    drive_cal_beat(ACT_START, 32'd5, 16'd0);
    settle_down();

    // One level past the top of the range: the first point ends the sweep.
    load_config(8'd250, 8'd255, 8'd255, 16'd0, 16'd0);
    drive_cal_beat(ACT_START, 32'd100, 16'd0);
    drive_cal_beat(ACT_UPDATE, 32'd100, 16'd0);
    drive_cal_beat(ACT_UPDATE, 32'd100, 16'd0);
    drive_cal_beat(ACT_UPDATE, 32'd101, 16'd0);
    drive_cal_beat(ACT_START, 32'd102, 16'd0);
    settle_down();

    // Longest windows and an end below the start.
    load_config(8'd255, 8'd0, 8'd1, 16'hFFFF, 16'hFFFF);
    drive_cal_beat(ACT_START, 32'd0, 16'd0);
    drive_cal_beat(ACT_UPDATE, 32'd65535, 16'd0);
    drive_cal_beat(ACT_UPDATE, 32'd131069, 16'hFFFF);
    drive_cal_beat(ACT_UPDATE, 32'd131070, 16'd0);
    settle_down();

    // Long sweeps that fill the point table, with a unit and a zero step, then a one-level range.
    run_phase(8'd0, 8'd255, 8'd1, 16'd0, 16'd0, 70, 70, 400);
    run_phase(8'd10, 8'd200, 8'd0, 16'd0, 16'd1, 70, 70, 500);
    run_phase(8'd128, 8'd128, 8'd3, 16'd7, 16'd9, 1, 4, 60);

    // Random settings with short sweeps.
    while (beats_sent < ItemGoal) begin
      r_start = pick_level();
      r_end   = pick_level();
      if ($urandom_range(0, 11) == 0) r_step = 8'd0;
      else if ($urandom_range(0, 1) == 0) r_step = 8'($urandom_range(1, 16));
      else r_step = 8'($urandom_range(1, 255));
      run_phase(r_start, r_end, r_step, pick_window(), pick_window(), 1, 10,
                $urandom_range(40, 160));
    end

    settle_down();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
